[sv/isqrt48_pkg.sv]
`default_nettype none

package isqrt48_pkg;

    // Radicand bits consumed by one cell: one root bit per pair of input bits
    localparam int unsigned DIGIT_BITS = 2;

endpackage

`default_nettype wire

[sv/integer_square_root_48.sv]
// Floor square root of an unsigned 2*ROOT_BITS-bit radicand (48 bits by default).
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// One cell per root bit, each a single registered trial subtract, sets the latency.
// Reset (rst_n, async, active low) clears the valid flags of all cells; no other state.
`default_nettype none

module integer_square_root_48 #(
    parameter int unsigned ROOT_BITS = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [2*ROOT_BITS-1:0]     radicand,
    output logic                            done,
    output logic [ROOT_BITS-1:0]            root
);

    logic                     valid_s [ROOT_BITS+1];
    logic [ROOT_BITS:0]       rem_s   [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]     root_s  [ROOT_BITS+1];
    logic [2*ROOT_BITS-1:0]   rad_s   [ROOT_BITS+1];

    // Chain head: empty remainder and root
    assign valid_s[0] = start;
    assign rem_s[0]   = '0;
    assign root_s[0]  = '0;
    assign rad_s[0]   = radicand;

    // One cell per root bit, most significant first
    for (genvar i = 0; i < ROOT_BITS; i++)
    begin : g_cell
        isqrt48_cell #(
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_s[i]),
            .in_rem    (rem_s[i]),
            .in_root   (root_s[i]),
            .in_rad    (rad_s[i]),
            .out_valid (valid_s[i+1]),
            .out_rem   (rem_s[i+1]),
            .out_root  (root_s[i+1]),
            .out_rad   (rad_s[i+1])
        );
    end

    assign busy = 1'b0;
    assign done = valid_s[ROOT_BITS];
    assign root = root_s[ROOT_BITS];

    // Every accepted item comes out of the last cell as a done strobe
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##ROOT_BITS done)
        else $error("item lost in root pipeline");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, ROOT_BITS))
        else $error("done without matching start");

    // Result is the floor root of the radicand that entered with the matching start
    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (({2'b00, {ROOT_BITS{1'b0}}, root} * {2'b00, {ROOT_BITS{1'b0}}, root})
                  <= {2'b00, $past(radicand, ROOT_BITS)}))
        else $error("root too large");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((({2'b00, {ROOT_BITS{1'b0}}, root} + 1'b1)
                   * ({2'b00, {ROOT_BITS{1'b0}}, root} + 1'b1))
                  > {2'b00, $past(radicand, ROOT_BITS)}))
        else $error("root too small");

endmodule

`default_nettype wire

[sv/isqrt48_cell.sv]
`default_nettype none

// One digit of the restoring square root: brings down the next two radicand
// bits, tries root bit 1, keeps it when the partial remainder covers it.
module isqrt48_cell #(
    parameter int unsigned ROOT_BITS = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [ROOT_BITS:0]         in_rem,
    input  wire logic [ROOT_BITS-1:0]       in_root,
    input  wire logic [2*ROOT_BITS-1:0]     in_rad,
    output logic                            out_valid,
    output logic [ROOT_BITS:0]              out_rem,
    output logic [ROOT_BITS-1:0]            out_root,
    output logic [2*ROOT_BITS-1:0]          out_rad
);

    localparam int unsigned DB = isqrt48_pkg::DIGIT_BITS;
    localparam int unsigned RW = ROOT_BITS + 1 + DB;

    logic                     valid_reg;
    logic [ROOT_BITS:0]       rem_reg;
    logic [ROOT_BITS:0]       rem_next;
    logic [ROOT_BITS-1:0]     root_reg;
    logic [ROOT_BITS-1:0]     root_next;
    logic [2*ROOT_BITS-1:0]   rad_reg;
    logic [2*ROOT_BITS-1:0]   rad_next;
    logic [RW-1:0]            rem_wide;
    logic [RW-1:0]            trial;
    logic [RW-1:0]            diff;
    logic                     keep;

    // Trial subtract: remainder*4 + next digit against root*4 + 1
    always_comb
    begin
        rem_wide  = {in_rem, in_rad[2*ROOT_BITS-1 -: DB]};
        trial     = {1'b0, in_root, {(DB-1){1'b0}}, 1'b1};
        diff      = rem_wide - trial;
        keep      = (rem_wide >= trial);
        rem_next  = keep ? diff[ROOT_BITS:0] : rem_wide[ROOT_BITS:0];
        root_next = {in_root[ROOT_BITS-2:0], keep};
        rad_next  = {in_rad[2*ROOT_BITS-DB-1:0], {DB{1'b0}}};
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;

    // Restoring invariant: remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({1'b0, rem_reg} <= {1'b0, root_reg, 1'b0}))
        else $error("cell remainder above twice partial root");

    default_check: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (rem_reg[ROOT_BITS] == 1'b0 || root_reg[ROOT_BITS-1] == 1'b1))
        else $error("cell remainder top bit set with small root");

endmodule

`default_nettype wire

[tb/integer_square_root_48_tb.sv]
module integer_square_root_48_tb;

    localparam int ROOT_W = 24;
    localparam int RAD_W = isqrt48_pkg::DIGIT_BITS * ROOT_W;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int NUM_PHASES = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [RAD_W-1:0]  radicand;
        logic [ROOT_W-1:0] root;
    } root_check_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [RAD_W-1:0] radicand = '0;
    logic busy;
    logic done;
    logic [ROOT_W-1:0] root;

    logic [RAD_W-1:0] radicand_queue[$];
    root_check_t pending_roots[$];
    int idle_pct = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    integer_square_root_48 #(
        .ROOT_BITS(ROOT_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .radicand(radicand),
        .done(done),
        .root(root)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Floor square root, one root bit per step from the top down
    function automatic logic [ROOT_W-1:0] floor_root_of(input logic [RAD_W-1:0] value);
        logic [ROOT_W-1:0] acc;
        logic [ROOT_W-1:0] trial;
        logic [RAD_W-1:0] square;
        acc = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = acc | (ROOT_W'(1) << b);
            square = RAD_W'(trial) * RAD_W'(trial);
            if (square <= value)
                acc = trial;
        end
        return acc;
    endfunction

    // Mix of full-range values, narrow values and values around perfect squares
    function automatic logic [RAD_W-1:0] random_radicand();
        logic [RAD_W-1:0] value;
        logic [ROOT_W-1:0] base;
        case ($urandom_range(0, 3))
            0, 3:
            begin
                value = RAD_W'({$urandom(), $urandom()});
            end
            1:
            begin
                value = RAD_W'({$urandom(), $urandom()});
                value = value >> $urandom_range(0, RAD_W - 1);
            end
            default:
            begin
                base = ROOT_W'($urandom());
                base = base >> $urandom_range(0, ROOT_W - 1);
                value = RAD_W'(base) * RAD_W'(base);
                value = value + RAD_W'($urandom_range(0, 2)) - RAD_W'(1);
            end
        endcase
        return value;
    endfunction

    // Wait until every queued item has been sent and every root has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (radicand_queue.size() != 0 || start || pending_roots.size() != 0);
    endtask

    // Driver: one new item per accepted start, random gaps per phase
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                pending_roots.push_back('{radicand: radicand,
                                          root: floor_root_of(radicand)});
            if (!start || !busy)
            begin
                if (radicand_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    radicand <= radicand_queue.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done strobe must match the oldest expected root
    always @(posedge clk)
    begin
        root_check_t exp_item;
        if (rst_n && done)
        begin
            if (pending_roots.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                $display("%0t: unexpected result: expected none, got root %0d", $time, root);
            end
            else
            begin
                exp_item = pending_roots.pop_front();
                if (root !== exp_item.root)
                begin
                    mismatch_count <= mismatch_count + 1;
                    $display("%0t: root mismatch for radicand %0d: expected %0d, got %0d",
                             $time, exp_item.radicand, exp_item.root, root);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus: directed corners, then random phases with varied sender gaps
    initial
    begin
        logic [ROOT_W-1:0] n;
        logic [RAD_W-1:0] v;
        int phase_idle[NUM_PHASES];

        // receiver cannot stall, so phases 0 and 2 run with no sender gaps
        phase_idle = '{0, 57, 0, 32};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // small radicands and field extremes
        for (int k = 0; k <= 16; k++)
        begin
            if (k <= 4 || k == 8 || k == 9 || k >= 15)
                radicand_queue.push_back(RAD_W'(k));
        end
        radicand_queue.push_back({RAD_W{1'b1}});
        radicand_queue.push_back({RAD_W{1'b1}} - RAD_W'(1));
        n = {ROOT_W{1'b1}};
        v = RAD_W'(n) * RAD_W'(n);
        radicand_queue.push_back(v);
        radicand_queue.push_back(v - RAD_W'(1));
        radicand_queue.push_back(RAD_W'(1) << (RAD_W - 1));
        radicand_queue.push_back(RAD_W'(1) << (RAD_W - 2));
        radicand_queue.push_back({RAD_W/2{2'b01}});
        radicand_queue.push_back({RAD_W/2{2'b10}});
        // a random perfect square and its neighbors
        n = ROOT_W'($urandom());
        v = RAD_W'(n) * RAD_W'(n);
        radicand_queue.push_back(v);
        radicand_queue.push_back(v - RAD_W'(1));
        radicand_queue.push_back(v + RAD_W'(1));
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct <= phase_idle[p];
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                radicand_queue.push_back(random_radicand());
            wait_drained();
        end

        // let any stray strobe show up before judging
        repeat (ROOT_W + 8) @(posedge clk);
        if (mismatch_count == 0 && pending_roots.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
sv/isqrt48_pkg.sv
sv/isqrt48_cell.sv
sv/integer_square_root_48.sv
tb/integer_square_root_48_tb.sv
